FILE: hw/rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// shared types and codes for the polynomial long division block
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

	localparam int IDX_BITS = 5;
	localparam int ORD_BITS = 5;
	localparam int ACT_BITS = 2;

	localparam logic [ACT_BITS-1:0] ACT_LOAD_DIVIDEND = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_LOAD_DIVISOR  = 2'd1;
	localparam logic [ACT_BITS-1:0] ACT_START         = 2'd2;

	localparam logic REG_DIVIDEND_ORDER = 1'b0;
	localparam logic REG_DIVISOR_ORDER  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_DIV,
		ST_DWAIT,
		ST_MUL,
		ST_SUB,
		ST_CLR,
		ST_OUT
	} state_t;

	// per-cycle commands broadcast to the cell row
	typedef struct packed {
		logic load_rem;
		logic load_div;
		logic start;
		logic shift_up;
		logic shift_down;
		logic mul;
		logic sub;
		logic clr_hi;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pld_div.sv
// ----------------------------------------------------------------------------
// pld_div
// restoring divider, one quotient bit per cycle, saturating result
// ----------------------------------------------------------------------------
`default_nettype none

module pld_div
	import pld_pkg::*;
#(
	parameter int CB   = 32,
	parameter int FRAC = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [CB-1:0] num_mag,
	input  wire logic [CB-1:0] den_mag,
	input  wire logic          neg,
	output logic               done,
	output logic [CB-1:0]      quo,
	output logic               sat
);

	localparam int NW = CB + FRAC;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [CB-1:0] r_q;
	logic [CB-1:0] d_q;
	logic          neg_q;

	logic [CB:0]   t;
	logic          ge;
	logic [CB:0]   t_sub;
	logic [NW-1:0] lim;

	assign t     = {r_q, n_q[NW-1]};
	assign ge    = t >= {1'b0, d_q};
	assign t_sub = t - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= NW'(num_mag) << FRAC;
			q_q   <= '0;
			r_q   <= '0;
			d_q   <= den_mag;
			neg_q <= neg;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			q_q <= {q_q[NW-2:0], ge};
			r_q <= ge ? t_sub[CB-1:0] : t[CB-1:0];
		end
	end

	// positive bound, one more for a negative result
	assign lim = {{(NW-CB+1){1'b0}}, {(CB-1){1'b1}}} + NW'(neg_q);

	always_comb begin
		sat = q_q > lim;
		if (sat)
			quo = neg_q ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		else
			quo = neg_q ? (~q_q[CB-1:0] + 1'b1) : q_q[CB-1:0];
	end

	assign done = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pld_cell.sv
// ----------------------------------------------------------------------------
// pld_cell
// one coefficient slot: dividend/remainder, divisor, shifted divisor, quotient
// ----------------------------------------------------------------------------
`default_nettype none

module pld_cell
	import pld_pkg::*;
#(
	parameter int CB   = 32,
	parameter int FRAC = 16,
	parameter int IW   = 5,
	parameter int IDX  = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [IW-1:0] sel,
	input  wire logic [IW-1:0] n1,
	input  wire logic [IW-1:0] n2,
	input  wire logic [CB-1:0] wr_value,
	input  wire logic [CB-1:0] q_value,
	input  wire logic [CB-1:0] q_mag,
	input  wire logic          q_neg,
	input  wire logic [CB-1:0] w_lo,
	input  wire logic          v_lo,
	input  wire logic [CB-1:0] w_hi,
	input  wire logic          v_hi,
	output logic [CB-1:0]      w,
	output logic               v,
	output logic [CB-1:0]      rem,
	output logic [CB-1:0]      div,
	output logic [CB-1:0]      quo,
	output logic               ovf
);

	localparam logic [IW-1:0] ME = IW'(IDX);

	logic [CB-1:0]   rem_q;
	logic [CB-1:0]   div_q;
	logic [CB-1:0]   w_q;
	logic            v_q;
	logic [CB-1:0]   quo_q;
	logic [2*CB-1:0] p_s1;
	logic            neg_s1;

	logic [CB-1:0]   w_mag;
	logic [2*CB-1:0] s;
	logic [2*CB-1:0] lim;
	logic            msat;
	logic [CB-1:0]   mmag;
	logic [CB-1:0]   mv;
	logic [CB:0]     diff;
	logic            ssat;
	logic [CB-1:0]   rem_new;

	assign w_mag = w_q[CB-1] ? (~w_q + 1'b1) : w_q;

	always_comb begin
		s    = p_s1 >> FRAC;
		lim  = {{(CB+1){1'b0}}, {(CB-1){1'b1}}} + (2*CB)'(neg_s1);
		msat = s > lim;
		mmag = msat ? lim[CB-1:0] : s[CB-1:0];
		mv   = neg_s1 ? (~mmag + 1'b1) : mmag;
		diff = {rem_q[CB-1], rem_q} - {mv[CB-1], mv};
		ssat = diff[CB] != diff[CB-1];
		if (ssat)
			rem_new = diff[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		else
			rem_new = diff[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			if (ctl.start)
				v_q <= IDX < int'(n2);
			else if (ctl.shift_up)
				v_q <= v_lo;
			else if (ctl.shift_down)
				v_q <= v_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_rem && sel == ME)
			rem_q <= wr_value;
		else if (ctl.sub && v_q)
			rem_q <= rem_new;
		else if (ctl.clr_hi && ME >= n2 && ME <= n1)
			rem_q <= '0;

		if (ctl.load_div && sel == ME)
			div_q <= wr_value;

		if (ctl.start)
			w_q <= div_q;
		else if (ctl.shift_up)
			w_q <= w_lo;
		else if (ctl.shift_down)
			w_q <= w_hi;

		if (ctl.start)
			quo_q <= '0;
		else if (ctl.mul && sel == ME)
			quo_q <= q_value;

		if (ctl.mul) begin
			p_s1   <= (2*CB)'(q_mag) * (2*CB)'(w_mag);
			neg_s1 <= q_neg ^ w_q[CB-1];
		end
	end

	assign w   = w_q;
	assign v   = v_q;
	assign rem = rem_q;
	assign div = div_q;
	assign quo = quo_q;
	assign ovf = ctl.sub && v_q && (msat || ssat);

endmodule

`default_nettype wire

FILE: hw/rtl/polynomial_long_division_top.sv
// ----------------------------------------------------------------------------
// polynomial_long_division_top
// fixed-point polynomial long division over a row of coefficient cells
// ----------------------------------------------------------------------------
// usage:
//   s_* channel: tuser carries the action (load dividend, load divisor, start),
//   tdata the coefficient index and value. loads are taken whenever the
//   block is idle.
//   a start runs the division and then sends 2*(dividend_order+1) items on
//   m_*: quotient terms 0..n1 (tuser=0), then remainder terms 0..n1
//   (tuser=1), tlast on the final remainder term.
//   steps of a start: the divisor is shifted up n1-n2 places to align it in
//   the row, then for each quotient term the one-bit-per-cycle divider
//   divides the top remainder term by the divisor's leading term, every
//   cell that holds a divisor term multiplies and subtracts at once, and
//   the divisor shifts down; then remainder terms n2..n1 are cleared.
//   the output register holds an item until m_tready; the block stalls
//   while it is full and m_tready is low. reset clears the control state,
//   order registers and flags; coefficient stores hold no value until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_long_division_top
	import pld_pkg::*;
#(
	parameter int MAX_ORDER  = 31,
	parameter int COEFF_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_addr,
	input  wire logic [ORD_BITS-1:0]  cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// coeff_index, coeff_value
	input  wire logic [((IDX_BITS+COEFF_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  wire logic [ACT_BITS-1:0]  s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_index, out_value, divide_error, overflow
	output logic [((IDX_BITS+COEFF_BITS+2+7)/8)*8-1:0] m_tdata,
	// part
	output logic                      m_tuser,
	output logic                      m_tlast
);

	localparam int CB    = COEFF_BITS;
	localparam int D     = MAX_ORDER + 1;
	localparam int IW    = (D > 2) ? $clog2(D) : 1;
	localparam int OD    = ((IDX_BITS + CB + 2 + 7) / 8) * 8;

	state_t state_q, state_d;
	cell_ctl_t ctl;

	logic [ORD_BITS-1:0] dividend_order_q;
	logic [ORD_BITS-1:0] divisor_order_q;
	logic [IW-1:0] n1, n2;
	logic [IW-1:0] k_q, a_q;
	logic [IW-1:0] pos_q;
	logic          part_q;
	logic [CB-1:0] lead_q;
	logic [CB-1:0] q_q;
	logic          err_div_q;
	logic          err_ovf_q;
	logic          ov_q;
	logic [OD-1:0] tdata_q;
	logic          tuser_q;
	logic          tlast_q;

	logic [IDX_BITS-1:0] in_idx;
	logic [CB-1:0]       in_val;
	logic                s_fire;
	logic                idx_ok;
	logic                out_load;
	logic                last_item;
	logic [IW-1:0]       sel;
	logic [IW-1:0]       rd_addr;
	logic [CB-1:0]       rd_rem;
	logic [CB-1:0]       top_mag, lead_mag, q_mag;
	logic                div_start, div_done, div_sat;
	logic [CB-1:0]       div_quo;
	logic [CB-1:0]       out_val;

	logic [CB-1:0] w_w   [D];
	logic          v_w   [D];
	logic [CB-1:0] rem_w [D];
	logic [CB-1:0] div_w [D];
	logic [CB-1:0] quo_w [D];
	logic [D-1:0]  ovf_w;

	assign in_idx = s_tdata[IDX_BITS-1:0];
	assign in_val = s_tdata[IDX_BITS +: CB];
	assign s_fire = s_tvalid && s_tready;
	assign idx_ok = int'(in_idx) <= MAX_ORDER;

	assign n1 = (int'(dividend_order_q) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(dividend_order_q);
	assign n2 = (int'(divisor_order_q) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(divisor_order_q);

	assign rd_addr  = (state_q == ST_OUT) ? pos_q : n2 + k_q;
	assign rd_rem   = rem_w[rd_addr];
	assign top_mag  = rd_rem[CB-1] ? (~rd_rem + 1'b1) : rd_rem;
	assign lead_mag = lead_q[CB-1] ? (~lead_q + 1'b1) : lead_q;
	assign q_mag    = q_q[CB-1] ? (~q_q + 1'b1) : q_q;
	assign out_val  = part_q ? rd_rem : quo_w[pos_q];
	assign last_item = part_q && pos_q == n1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dividend_order_q <= '0;
			divisor_order_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DIVIDEND_ORDER: dividend_order_q <= cfg_wdata;
				REG_DIVISOR_ORDER:  divisor_order_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (s_fire && s_tuser == ACT_START)
					state_d = (n2 > n1) ? ST_OUT : ST_ALIGN;
			ST_ALIGN:
				if (a_q == '0)
					state_d = ST_DIV;
			ST_DIV:
				state_d = (lead_q == '0) ? ST_MUL : ST_DWAIT;
			ST_DWAIT:
				if (div_done)
					state_d = ST_MUL;
			ST_MUL:
				state_d = ST_SUB;
			ST_SUB:
				state_d = (k_q == '0) ? ST_CLR : ST_DIV;
			ST_CLR:
				state_d = ST_OUT;
			ST_OUT:
				if (out_load && last_item)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl       = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		s_tready  = 1'b0;
		sel       = k_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				sel      = IW'(in_idx);
				ctl.load_rem = s_fire && s_tuser == ACT_LOAD_DIVIDEND && idx_ok;
				ctl.load_div = s_fire && s_tuser == ACT_LOAD_DIVISOR && idx_ok;
				ctl.start    = s_fire && s_tuser == ACT_START;
			end
			ST_ALIGN:
				ctl.shift_up = a_q != '0;
			ST_DIV:
				div_start = lead_q != '0;
			ST_DWAIT: ;
			ST_MUL:
				ctl.mul = 1'b1;
			ST_SUB: begin
				ctl.sub        = 1'b1;
				ctl.shift_down = 1'b1;
			end
			ST_CLR:
				ctl.clr_hi = 1'b1;
			ST_OUT:
				out_load = !ov_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			err_div_q <= 1'b0;
			err_ovf_q <= 1'b0;
			ov_q      <= 1'b0;
			part_q    <= 1'b0;
			pos_q     <= '0;
			k_q       <= '0;
			a_q       <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.start) begin
				err_div_q <= 1'b0;
				err_ovf_q <= 1'b0;
				part_q    <= 1'b0;
				pos_q     <= '0;
				k_q       <= n1 - n2;
				a_q       <= n1 - n2;
			end
			if (ctl.shift_up)
				a_q <= a_q - 1'b1;
			if (state_q == ST_DIV && lead_q == '0)
				err_div_q <= 1'b1;
			if (state_q == ST_DWAIT && div_done && div_sat)
				err_ovf_q <= 1'b1;
			if (ctl.sub) begin
				if (|ovf_w)
					err_ovf_q <= 1'b1;
				if (k_q != '0)
					k_q <= k_q - 1'b1;
			end
			if (out_load) begin
				ov_q <= 1'b1;
				if (pos_q == n1) begin
					pos_q  <= '0;
					part_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start)
			lead_q <= div_w[n2];
		if (state_q == ST_DIV && lead_q == '0) begin
			if (rd_rem == '0)
				q_q <= '0;
			else
				q_q <= rd_rem[CB-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end else if (state_q == ST_DWAIT && div_done) begin
			q_q <= div_quo;
		end
		if (out_load) begin
			tdata_q <= OD'({err_ovf_q, err_div_q, out_val, IDX_BITS'(pos_q)});
			tuser_q <= part_q;
			tlast_q <= last_item;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

	pld_div #(
		.CB   (CB),
		.FRAC (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (top_mag),
		.den_mag (lead_mag),
		.neg     (rd_rem[CB-1] ^ lead_q[CB-1]),
		.done    (div_done),
		.quo     (div_quo),
		.sat     (div_sat)
	);

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [CB-1:0] w_lo, w_hi;
		logic          v_lo, v_hi;
		if (i == 0) begin : g_lo0
			assign w_lo = '0;
			assign v_lo = 1'b0;
		end else begin : g_lo
			assign w_lo = w_w[i-1];
			assign v_lo = v_w[i-1];
		end
		if (i == D-1) begin : g_hi0
			assign w_hi = '0;
			assign v_hi = 1'b0;
		end else begin : g_hi
			assign w_hi = w_w[i+1];
			assign v_hi = v_w[i+1];
		end

		pld_cell #(
			.CB   (CB),
			.FRAC (FRAC_BITS),
			.IW   (IW),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sel      (sel),
			.n1       (n1),
			.n2       (n2),
			.wr_value (in_val),
			.q_value  (q_q),
			.q_mag    (q_mag),
			.q_neg    (q_q[CB-1]),
			.w_lo     (w_lo),
			.v_lo     (v_lo),
			.w_hi     (w_hi),
			.v_hi     (v_hi),
			.w        (w_w[i]),
			.v        (v_w[i]),
			.rem      (rem_w[i]),
			.div      (div_w[i]),
			.quo      (quo_w[i]),
			.ovf      (ovf_w[i])
		);
	end

endmodule

`default_nettype wire
